[hdl/swd_pkg.sv]
// Package for the sync-word deframer: sync length, phase and kind codes,
// and the result record type. Used by every module of the block.
`default_nettype none
package swd_pkg;

    localparam int SYNC_BYTES  = 8;
    localparam int SYNC_CNT_W  = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;
    localparam int SYNC_W      = 64;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_ID_HI  = 3'd1;
    localparam logic [2:0] PH_ID_LO  = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_LEN_LO = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;

    localparam logic [1:0] KIND_DATA       = 2'd0;
    localparam logic [1:0] KIND_EMPTY      = 2'd1;
    localparam logic [1:0] KIND_STREAM_ERR = 2'd2;

    typedef struct packed {
        logic [15:0] byte_index;
        logic [7:0]  payload_byte;
        logic [15:0] packet_id;
        logic [1:0]  kind;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

[hdl/swd_parser.sv]
// Deframer parse state: sync hunt, id and length capture, payload indexing.
// Depends on swd_pkg.
`default_nettype none
module swd_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [swd_pkg::SYNC_W-1:0]    i_sync_word,
    input  wire logic                          i_valid,
    input  wire logic [7:0]                    i_byte,
    input  wire logic                          i_err,
    input  wire logic                          i_advance,
    output logic                               o_has_result,
    output swd_pkg::t_result                   o_result
);

    logic [2:0]                     r_phase, n_phase;
    logic [swd_pkg::SYNC_CNT_W-1:0] r_match, n_match;
    logic [15:0]                    r_id, n_id;
    logic [15:0]                    r_len, n_len;
    logic [15:0]                    r_done, n_done;
    logic [swd_pkg::SYNC_CNT_W-1:0] w_sel;
    logic [7:0]                     w_expect;
    logic [16:0]                    w_idx_inc;
    logic                           w_last;
    logic                           w_has;
    swd_pkg::t_result               w_res;

    assign w_sel     = swd_pkg::SYNC_CNT_W'(swd_pkg::SYNC_BYTES - 1) - r_match;
    assign w_expect  = i_sync_word[{w_sel, 3'b000} +: 8];
    assign w_idx_inc = {1'b0, r_done} + 17'd1;
    assign w_last    = (w_idx_inc >= {1'b0, r_len});

    always_comb begin
        n_phase = r_phase;
        n_match = r_match;
        n_id    = r_id;
        n_len   = r_len;
        n_done  = r_done;
        w_has   = 1'b0;
        w_res   = '0;
        if (i_err) begin
            w_has      = 1'b1;
            w_res.kind = swd_pkg::KIND_STREAM_ERR;
            w_res.last = 1'b1;
            if (r_phase == swd_pkg::PH_LEN_HI || r_phase == swd_pkg::PH_LEN_LO ||
                r_phase == swd_pkg::PH_DATA) begin
                w_res.packet_id = r_id;
            end
            n_phase = swd_pkg::PH_HUNT;
            n_match = '0;
        end else begin
            unique case (r_phase)
                swd_pkg::PH_ID_HI: begin
                    n_id    = {i_byte, 8'h00};
                    n_phase = swd_pkg::PH_ID_LO;
                end
                swd_pkg::PH_ID_LO: begin
                    n_id    = {r_id[15:8], i_byte};
                    n_phase = swd_pkg::PH_LEN_HI;
                end
                swd_pkg::PH_LEN_HI: begin
                    n_len   = {i_byte, 8'h00};
                    n_phase = swd_pkg::PH_LEN_LO;
                end
                swd_pkg::PH_LEN_LO: begin
                    n_len  = {r_len[15:8], i_byte};
                    n_done = '0;
                    if ({r_len[15:8], i_byte} == 16'd0) begin
                        w_has           = 1'b1;
                        w_res.kind      = swd_pkg::KIND_EMPTY;
                        w_res.packet_id = r_id;
                        w_res.last      = 1'b1;
                        n_phase         = swd_pkg::PH_HUNT;
                        n_match         = '0;
                    end else begin
                        n_phase = swd_pkg::PH_DATA;
                    end
                end
                swd_pkg::PH_DATA: begin
                    w_has              = 1'b1;
                    w_res.kind         = swd_pkg::KIND_DATA;
                    w_res.packet_id    = r_id;
                    w_res.payload_byte = i_byte;
                    w_res.byte_index   = r_done;
                    w_res.last         = w_last;
                    n_done             = w_idx_inc[15:0];
                    if (w_last) begin
                        n_phase = swd_pkg::PH_HUNT;
                        n_match = '0;
                    end
                end
                default: begin
                    // hunt; unused codes hunt too, from a zero match count
                    n_phase = swd_pkg::PH_HUNT;
                    if (r_phase == swd_pkg::PH_HUNT && i_byte == w_expect) begin
                        if (r_match == swd_pkg::SYNC_CNT_W'(swd_pkg::SYNC_BYTES - 1)) begin
                            n_match = '0;
                            n_phase = swd_pkg::PH_ID_HI;
                        end else begin
                            n_match = r_match + swd_pkg::SYNC_CNT_W'(1);
                        end
                    end else if (r_phase != swd_pkg::PH_HUNT &&
                                 i_byte == i_sync_word[8*(swd_pkg::SYNC_BYTES-1) +: 8]) begin
                        if (swd_pkg::SYNC_BYTES == 1) begin
                            n_match = '0;
                            n_phase = swd_pkg::PH_ID_HI;
                        end else begin
                            n_match = swd_pkg::SYNC_CNT_W'(1);
                        end
                    end else begin
                        n_match = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= swd_pkg::PH_HUNT;
            r_match <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_done  <= '0;
        end else if (i_valid && i_advance) begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_id    <= n_id;
            r_len   <= n_len;
            r_done  <= n_done;
        end
    end

    assign o_has_result = i_valid && w_has;
    assign o_result     = w_res;

endmodule
`default_nettype wire

[hdl/swd_out_stage.sv]
// Result register of the deframer: holds one result item until taken.
// Depends on swd_pkg.
`default_nettype none
module swd_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire swd_pkg::t_result   i_result,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output logic                    o_free,
    output swd_pkg::t_result        o_result
);

    logic             r_valid;
    swd_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

[hdl/sync_word_length_prefixed_deframer_top.sv]
// Sync-word, length-prefixed deframer top level: input register, parser,
// result register and sync word register. Depends on swd_pkg, swd_parser,
// swd_out_stage.
//
// Use: bytes enter on the slave stream (tdata = byte, tuser = read error
// flag). The block hunts for the sync word, most significant byte first,
// then takes a big-endian packet id and length and emits one result item
// per payload byte on the master stream; an empty packet or a stream error
// gives a single error item with tlast set.
// The sync word is written on the cfg channel, which is always ready; write
// it only while the block is idle.
// A result passes the input register, then the result register, before it is
// valid on the master stream. Throughput: one byte per cycle, set by the
// combinational parse step between the two registers, unless the receiver stalls.
// A stalled receiver holds the result register; bytes that make no result
// keep flowing, and the next byte that makes a result waits in the input
// register, which drops tready.
// Reset: clears the parse state to sync hunt, the sync word to zero and
// both registers to empty.
`default_nettype none
module sync_word_length_prefixed_deframer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // rx_byte
    input  wire logic        i_s_tuser,   // rx_error
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // packet_id, payload_byte, byte_index
    output logic [1:0]       o_m_tuser,   // kind
    output logic             o_m_tlast
);

    logic [swd_pkg::SYNC_W-1:0] r_sync_word;
    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_err;
    logic                       w_advance;
    logic                       w_has_result;
    logic                       w_out_free;
    swd_pkg::t_result           w_result;
    swd_pkg::t_result           w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= '0;
        end else if (i_cfg_valid) begin
            r_sync_word <= i_cfg_data;
        end
    end

    assign w_advance  = r_in_valid && (w_out_free || !w_has_result);
    assign o_s_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_err  <= i_s_tuser;
        end
    end

    swd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sync_word  (r_sync_word),
        .i_valid      (r_in_valid),
        .i_byte       (r_in_byte),
        .i_err        (r_in_err),
        .i_advance    (w_advance),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    swd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_has_result),
        .i_result (w_result),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_free   (w_out_free),
        .o_result (w_out)
    );

    assign o_m_tdata = {w_out.byte_index, w_out.payload_byte, w_out.packet_id};
    assign o_m_tuser = w_out.kind;
    assign o_m_tlast = w_out.last;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_err))
        else $error("input register lost a waiting item");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != swd_pkg::KIND_DATA |-> o_m_tlast)
        else $error("error result without last mark");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != swd_pkg::KIND_DATA |-> o_m_tdata[39:16] == 24'd0)
        else $error("error result carries payload fields");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser == swd_pkg::KIND_DATA || o_m_tuser == swd_pkg::KIND_EMPTY ||
                       o_m_tuser == swd_pkg::KIND_STREAM_ERR)
        else $error("result kind out of range");

endmodule
`default_nettype wire

[test/swd_checker.sv]
// Result checker for the sync-word deframer: tracks the sync word writes, predicts
// the result item, if any, of every accepted input byte and compares each output item.
// Depends on swd_pkg.
`timescale 1ns / 100ps
module swd_checker
    import swd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // rx_byte
    input  wire logic        i_s_tuser,   // rx_error
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [39:0] i_m_tdata,   // packet_id, payload_byte, byte_index
    input  wire logic [1:0]  i_m_tuser,   // kind
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending
);

    t_result     pending_results[$];
    logic [63:0] sync_word;
    logic [2:0]  parse_phase;
    int unsigned sync_hits;
    logic [15:0] pkt_id;
    logic [15:0] pkt_len;
    logic [15:0] bytes_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_result make_result(logic [1:0] kind, logic [15:0] id,
                                            logic [7:0] data, logic [15:0] idx,
                                            logic last);
        t_result r;
        r.kind         = kind;
        r.packet_id    = id;
        r.payload_byte = data;
        r.byte_index   = idx;
        r.last         = last;
        return r;
    endfunction

    function automatic void rehunt();
        parse_phase = PH_HUNT;
        sync_hits   = 0;
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b, logic err);
        int unsigned m;
        logic [7:0]  want;
        logic [15:0] idx;
        logic        last;
        if (parse_phase > PH_DATA) rehunt();
        if (err) begin
            pending_results.push_back(make_result(KIND_STREAM_ERR,
                (parse_phase >= PH_LEN_HI) ? pkt_id : 16'h0000, 8'h00, 16'h0000, 1'b1));
            rehunt();
            return;
        end
        case (parse_phase)
            PH_HUNT: begin
                m = (sync_hits >= SYNC_BYTES) ? 0 : sync_hits;
                want = sync_word[(SYNC_BYTES - 1 - m) * 8 +: 8];
                if (b == want) begin
                    m++;
                    if (m >= SYNC_BYTES) begin
                        sync_hits   = 0;
                        parse_phase = PH_ID_HI;
                    end else begin
                        sync_hits = m;
                    end
                end else begin
                    sync_hits = 0;
                end
            end
            PH_ID_HI: begin
                pkt_id      = {b, 8'h00};
                parse_phase = PH_ID_LO;
            end
            PH_ID_LO: begin
                pkt_id[7:0] = b;
                parse_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                pkt_len     = {b, 8'h00};
                parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                pkt_len[7:0] = b;
                bytes_seen   = '0;
                if (pkt_len == 16'h0000) begin
                    pending_results.push_back(make_result(KIND_EMPTY, pkt_id, 8'h00,
                                                          16'h0000, 1'b1));
                    rehunt();
                end else begin
                    parse_phase = PH_DATA;
                end
            end
            default: begin
                idx  = bytes_seen;
                last = ({1'b0, idx} + 17'd1 >= {1'b0, pkt_len});
                pending_results.push_back(make_result(KIND_DATA, pkt_id, b, idx, last));
                bytes_seen = idx + 16'd1;
                if (last) rehunt();
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            sync_word   = '0;
            pkt_id      = '0;
            pkt_len     = '0;
            bytes_seen  = '0;
            rehunt();
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) sync_word = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result item with none expected: kind %0h tdata %0h",
                           i_m_tuser, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, i_m_tuser);
                    check_field("packet_id", want.packet_id, i_m_tdata[15:0]);
                    check_field("payload_byte", want.payload_byte, i_m_tdata[23:16]);
                    check_field("byte_index", want.byte_index, i_m_tdata[39:24]);
                    check_field("last", want.last, i_m_tlast);
                end
            end
            if (i_s_tvalid && i_s_tready) parse_rx_byte(i_s_tdata, i_s_tuser);
        end
        o_pending <= pending_results.size();
    end

endmodule

[test/tb.sv]
// Testbench top for sync_word_length_prefixed_deframer_top: clock, reset, byte
// stimulus, sync word writes and result backpressure. Depends on swd_pkg and
// swd_checker.
`timescale 1ns / 100ps
module tb;
    import swd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 5;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [63:0] i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;
    int          items_sent  = 0;
    bit          gaps_on     = 1'b1;
    bit          hold_req    = 1'b0;
    logic [63:0] cur_sync    = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sync_word_length_prefixed_deframer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    swd_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_m_tlast   (o_m_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // hold off on request, else stall in random bursts while gaps are on
    initial begin
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_m_tready <= 1'b0;
                end
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 10)) begin
                    @(negedge i_clk);
                    i_m_tready <= 1'b0;
                end
            end else begin
                @(negedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic err);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 10)) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= err;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // send sync, id, length and payload; replace item err_at by a stream error and end the frame there
    task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                              input int err_at);
        int         total;
        int         i;
        logic [7:0] b;
        total = SYNC_BYTES + 4 + len;
        for (i = 0; i < total; i++) begin
            if (i == err_at) begin
                send_item(8'($urandom), 1'b1);
                break;
            end
            if (i < SYNC_BYTES) begin
                b = cur_sync[(SYNC_BYTES - 1 - i) * 8 +: 8];
            end else begin
                case (i - SYNC_BYTES)
                    0:       b = id[15:8];
                    1:       b = id[7:0];
                    2:       b = len[15:8];
                    3:       b = len[7:0];
                    default: b = 8'($urandom);
                endcase
            end
            send_item(b, 1'b0);
        end
    endtask

    task automatic send_noise(input int n);
        int         i;
        logic [7:0] b;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                b = cur_sync[$urandom_range(0, SYNC_BYTES - 1) * 8 +: 8];
            end else begin
                b = 8'($urandom);
            end
            send_item(b, $urandom_range(0, 9) == 0);
        end
    endtask

    // drain, let the pipeline settle, then write the sync word
    task automatic write_sync(input logic [63:0] value);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_sync = value;
    endtask

    task automatic random_step();
        int          r;
        int          i;
        int          k;
        logic [15:0] len;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(9, 40))
                                               : 16'($urandom_range(1, 8));
            send_frame(16'($urandom), len, -1);
        end else if (r < 60) begin
            send_frame(16'($urandom), 16'h0000, -1);
        end else if (r < 72) begin
            send_frame(16'($urandom), 16'($urandom),
                       $urandom_range(0, SYNC_BYTES + 7));
        end else if (r < 82) begin
            send_noise($urandom_range(1, 6));
        end else if (r < 92) begin
            k = $urandom_range(1, SYNC_BYTES - 1);
            for (i = 0; i < k; i++) send_item(cur_sync[(SYNC_BYTES - 1 - i) * 8 +: 8], 1'b0);
            send_item(8'($urandom), 1'b0);
        end else begin
            send_item(8'($urandom), 1'b1);
        end
    endtask

    initial begin
        int          ph;
        int          i;
        int          target;
        logic [63:0] sync_val;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_frame(16'hFFFF, 16'h0001, -1);
        send_item(8'hFF, 1'b1);
        write_sync(64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(16'h0000, 16'h0000, -1);
        send_frame(16'h1234, 16'hFFFF, SYNC_BYTES + 1);
        send_frame(16'hABCD, 16'h8000, SYNC_BYTES + 3);
        write_sync(64'h5A5A_5A5A_5A5A_5A3C);
        for (i = 0; i < SYNC_BYTES; i++) send_item(8'h5A, 1'b0);
        send_frame(16'h00FF, 16'h0002, -1);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       sync_val = 64'h0;
                1:       sync_val = 64'h5A5A_5A5A_5A5A_5A3C;
                default: sync_val = {$urandom, $urandom};
            endcase
            gaps_on = (ph != NUM_PHASES - 1);
            write_sync(sync_val);
            if (ph == 0) begin
                hold_req = 1'b1;
                send_frame(16'($urandom), 16'd40, -1);
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_step();
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
